// ===== sv/assert_macros.svh =====
// Assertion helpers for the calu_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds at an edge -> consequent holds at the same edge.
`define CALU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds at an edge -> consequent holds at the next edge.
`define CALU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/calu_pkg.sv =====
package calu_pkg;

  localparam logic [3:0] OP_ADD8  = 4'd0;
  localparam logic [3:0] OP_ADC   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SBC   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_XOR   = 4'd5;
  localparam logic [3:0] OP_OR    = 4'd6;
  localparam logic [3:0] OP_CP    = 4'd7;
  localparam logic [3:0] OP_ADD16 = 4'd8;
  localparam logic [3:0] OP_ADDSP = 4'd9;
  localparam logic [3:0] OP_DAA   = 4'd10;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] BCD_MAX    = 4'h9;

endpackage

// ===== sv/cpu_alu_with_flags.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------
// command   | start, busy        | opcode, operand_a, operand_b, flags_in
// result    | done (strobe)      | result, flags_out
//
// One transaction per clock; busy is low whenever rst is low.
// The result strobes done after one input register and one result register,
// which bracket the single ALU pass.
// rst is synchronous, active high; it clears the valid pipeline and holds busy.
// The receiver cannot stall; done is a one-cycle pulse per transaction.
module cpu_alu_with_flags
  import calu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [3:0]  flags_in,
  output logic        done,
  output logic [15:0] result,
  output logic [3:0]  flags_out
);

  logic        in_valid;
  logic [3:0]  in_op;
  logic [15:0] in_a;
  logic [15:0] in_b;
  logic [3:0]  in_flags;
  logic [15:0] result_next;
  logic [3:0]  flags_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
    in_op     <= opcode;
    in_a      <= operand_a;
    in_b      <= operand_b;
    in_flags  <= flags_in;
    result    <= result_next;
    flags_out <= flags_next;
  end

  calu_core u_core (
    .opcode    (in_op),
    .operand_a (in_a),
    .operand_b (in_b),
    .flags_in  (in_flags),
    .result    (result_next),
    .flags_out (flags_next)
  );

endmodule

// ===== sv/calu_core.sv =====
module calu_core
  import calu_pkg::*;
(
  input  logic [3:0]  opcode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [3:0]  flags_in,
  output logic [15:0] result,
  output logic [3:0]  flags_out
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_dif;
  logic [4:0]  sub_half;
  logic [8:0]  sp_lo_sum;
  logic [4:0]  sp_half;
  logic [15:0] sp_sum;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic        daa_n;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_val;

  assign a8  = operand_a[7:0];
  assign b8  = operand_b[7:0];
  assign cin = (opcode == OP_ADC || opcode == OP_SBC) ? flags_in[FLAG_C] : 1'b0;

  assign add_sum  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
  assign add_half = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign sub_dif  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
  assign sub_half = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};

  assign sp_lo_sum = {1'b0, a8} + {1'b0, b8};
  assign sp_half   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
  assign sp_sum    = operand_a + {{8{b8[7]}}, b8};

  assign w_sum  = {1'b0, operand_a} + {1'b0, operand_b};
  assign w_half = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};

  // Subtract mode reuses the incoming C/H as the adjust selects.
  assign daa_n   = flags_in[FLAG_N];
  assign daa_hi  = daa_n ? flags_in[FLAG_C] : (flags_in[FLAG_C] || a8 > DAA_LIMIT);
  assign daa_lo  = daa_n ? flags_in[FLAG_H] : (flags_in[FLAG_H] || a8[3:0] > BCD_MAX);
  assign daa_adj = (daa_hi ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
  assign daa_val = daa_n ? (a8 - daa_adj) : (a8 + daa_adj);

  always_comb begin
    result    = operand_a;
    flags_out = flags_in;
    unique case (opcode)
      OP_ADD8, OP_ADC: begin
        result    = {8'd0, add_sum[7:0]};
        flags_out = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        result    = (opcode == OP_CP) ? operand_a : {8'd0, sub_dif[7:0]};
        flags_out = {sub_dif[7:0] == 8'd0, 1'b1, sub_half[4], sub_dif[8]};
      end
      OP_AND: begin
        result    = {8'd0, a8 & b8};
        flags_out = {(a8 & b8) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        result    = {8'd0, a8 ^ b8};
        flags_out = {(a8 ^ b8) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        result    = {8'd0, a8 | b8};
        flags_out = {(a8 | b8) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      OP_ADD16: begin
        result    = w_sum[15:0];
        flags_out = {flags_in[FLAG_Z], 1'b0, w_half[12], w_sum[16]};
      end
      OP_ADDSP: begin
        result    = sp_sum;
        flags_out = {1'b0, 1'b0, sp_half[4], sp_lo_sum[8]};
      end
      OP_DAA: begin
        result    = {8'd0, daa_val};
        flags_out = {daa_val == 8'd0, daa_n, 1'b0, daa_hi};
      end
      default: begin
        result    = operand_a;
        flags_out = flags_in;
      end
    endcase
  end

endmodule

// ===== sv/calu_checker.sv =====
`include "assert_macros.svh"

module calu_checker
  import calu_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [3:0]  opcode,
  input logic [15:0] operand_a,
  input logic [15:0] operand_b,
  input logic [3:0]  flags_in,
  input logic        done,
  input logic [15:0] result,
  input logic [3:0]  flags_out
);

  `CALU_ASSERT_IMP(a_done_latency, clk, rst, 1'b1, done == $past(start && !busy, 2), "done does not follow accept by two cycles")

  `CALU_ASSERT_NXT(a_one_per_accept, clk, rst, start && !busy, !busy, "busy raised outside reset")

  `CALU_ASSERT_IMP(a_cp_passthru, clk, rst, done && $past(opcode, 2) == OP_CP, result == $past(operand_a, 2), "cp changed the operand")

  `CALU_ASSERT_IMP(a_byte_ops_hi_zero, clk, rst, done && $past(opcode, 2) < OP_CP, result[15:8] == 8'd0, "8-bit op set upper byte")

  `CALU_ASSERT_IMP(a_logic_flags, clk, rst, done && ($past(opcode, 2) == OP_AND || $past(opcode, 2) == OP_XOR || $past(opcode, 2) == OP_OR), !flags_out[FLAG_N] && !flags_out[FLAG_C], "logic op set N or C")

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (.*);

// ===== bench/alu_flag_checker.sv =====
`timescale 1ns / 100ps

module alu_flag_checker
  import calu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [3:0]  opcode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [3:0]  flags_in,
  input  logic        done,
  input  logic [15:0] result,
  input  logic [3:0]  flags_out,
  output int          mismatches,
  output int          in_flight
);

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] value;
    logic [3:0]  flags;
  } alu_out_t;

  alu_out_t pending_results[$];
  int       bad_count = 0;
  int       depth = 0;

  assign mismatches = bad_count;
  assign in_flight  = depth;

  function automatic logic [3:0] pack_znhc(input logic z, input logic n, input logic h,
                                           input logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  function automatic alu_out_t alu_compute(input logic [3:0] op, input logic [15:0] a16,
                                           input logic [15:0] b16, input logic [3:0] fin);
    alu_out_t    r;
    int unsigned a, b, cy, sum, lo, hi;
    int          v;
    logic        n_in, h_in, c_in, c_out;
    a    = a16[7:0];
    b    = b16[7:0];
    n_in = fin[FLAG_N];
    h_in = fin[FLAG_H];
    c_in = fin[FLAG_C];
    r.op    = op;
    r.value = a16;
    r.flags = fin;
    case (op)
      OP_ADD8, OP_ADC: begin
        cy  = (op == OP_ADC) ? c_in : 1'b0;
        sum = a + b + cy;
        lo  = a[3:0] + b[3:0] + cy;
        r.value = {8'h00, sum[7:0]};
        r.flags = pack_znhc(sum[7:0] == 8'h00, 1'b0, lo > 15, sum > 255);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy  = (op == OP_SBC) ? c_in : 1'b0;
        sum = a - b - cy;
        lo  = b[3:0] + cy;
        hi  = b + cy;
        r.flags = pack_znhc(sum[7:0] == 8'h00, 1'b1, a[3:0] < lo, a < hi);
        if (op != OP_CP) begin
          r.value = {8'h00, sum[7:0]};
        end
      end
      OP_AND: begin
        sum = a & b;
        r.value = sum[15:0];
        r.flags = pack_znhc(sum == 0, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        sum = a ^ b;
        r.value = sum[15:0];
        r.flags = pack_znhc(sum == 0, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        sum = a | b;
        r.value = sum[15:0];
        r.flags = pack_znhc(sum == 0, 1'b0, 1'b0, 1'b0);
      end
      OP_ADD16: begin
        sum = a16 + b16;
        lo  = a16[11:0] + b16[11:0];
        r.value = sum[15:0];
        r.flags = pack_znhc(fin[FLAG_Z], 1'b0, lo > 'hFFF, sum > 'hFFFF);
      end
      OP_ADDSP: begin
        // offset is the sign-extended low byte of b
        sum = a16 + {{8{b16[7]}}, b16[7:0]};
        lo  = a16[3:0] + b16[3:0];
        hi  = a16[7:0] + b16[7:0];
        r.value = sum[15:0];
        r.flags = pack_znhc(1'b0, 1'b0, lo > 15, hi > 255);
      end
      OP_DAA: begin
        v     = a;
        c_out = c_in;
        if (!n_in) begin
          if (c_in || v > DAA_LIMIT) begin
            v     = v + DAA_HI_ADJ;
            c_out = 1'b1;
          end
          if (h_in || (v & 15) > BCD_MAX) begin
            v = v + DAA_LO_ADJ;
          end
        end else begin
          if (c_in) begin
            v = v - DAA_HI_ADJ;
          end
          if (h_in) begin
            v = v - DAA_LO_ADJ;
          end
        end
        r.value = {8'h00, v[7:0]};
        r.flags = pack_znhc(v[7:0] == 8'h00, n_in, 1'b0, c_out);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_out_t want;
    if (rst) begin
      pending_results.delete();
      depth <= 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          if (bad_count < 10) begin
            $display("alu: result strobe with no transaction outstanding: result %h flags %b",
                     result, flags_out);
          end
          bad_count++;
        end else begin
          want = pending_results.pop_front();
          if (result !== want.value || flags_out !== want.flags) begin
            if (bad_count < 10) begin
              $display("alu: op %0d expected result %h flags %b, got result %h flags %b",
                       want.op, want.value, want.flags, result, flags_out);
            end
            bad_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.push_back(alu_compute(opcode, operand_a, operand_b, flags_in));
      end
      depth <= pending_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import calu_pkg::*;

  localparam logic [3:0] OP_SPARE_FIRST  = OP_DAA + 4'd1;
  localparam logic [3:0] OP_SPARE_LAST   = 4'hF;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         ITEMS_PER_PHASE = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  opcode = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [3:0]  flags_in = '0;
  logic        busy;
  logic        done;
  logic [15:0] result;
  logic [3:0]  flags_out;

  int mismatches;
  int in_flight;
  int idle_pct = 0;
  int cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cpu_alu_with_flags uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .flags_in  (flags_in),
    .done      (done),
    .result    (result),
    .flags_out (flags_out)
  );

  alu_flag_checker chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .flags_in   (flags_in),
    .done       (done),
    .result     (result),
    .flags_out  (flags_out),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // start stays high across back-to-back transactions
  task automatic issue(input logic [3:0] op, input logic [15:0] a, input logic [15:0] b,
                       input logic [3:0] f);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    flags_in  <= f;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(7))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'hFF;
      2: w[3:0] = 4'hF;
      3: w[7:0] = 8'($urandom_range(DAA_LIMIT));
      4: w = 16'hFFFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] pick_op();
    if ($urandom_range(19) == 0) begin
      return 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end
    return 4'($urandom_range(OP_DAA, OP_ADD8));
  endfunction

  initial begin
    int op_i;
    int phase;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (op_i = OP_ADD8; op_i <= OP_DAA; op_i++) begin
      issue(op_i[3:0], 16'hFFFF, 16'hFFFF, 4'hF);
    end
    issue(OP_ADD8, 16'h0000, 16'h0000, 4'h0);
    issue(OP_ADC, 16'h000F, 16'h0000, 4'h1);
    issue(OP_SBC, 16'h0010, 16'h000F, 4'h1);
    issue(OP_SBC, 16'h0000, 16'h00FF, 4'h1);
    issue(OP_CP, 16'hABCD, 16'h00CD, 4'h0);
    issue(OP_AND, 16'h0F0F, 16'hF0F0, 4'h0);
    issue(OP_ADD16, 16'h0FFF, 16'h0001, 4'h8);
    issue(OP_ADD16, 16'hFFFF, 16'h0001, 4'h0);
    issue(OP_ADDSP, 16'h1000, 16'hFF80, 4'hF);
    issue(OP_ADDSP, 16'h00FF, 16'h0001, 4'h0);
    issue(OP_DAA, 16'h009A, 16'h0000, 4'h0);
    issue(OP_DAA, 16'h000A, 16'h0000, 4'h2);
    issue(OP_DAA, 16'h0000, 16'h0000, 4'h7);
    issue(OP_DAA, 16'h0066, 16'h0000, 4'h4);
    issue(OP_SPARE_FIRST, 16'h5A5A, 16'hA5A5, 4'h9);
    issue(OP_SPARE_LAST, 16'h0000, 16'hFFFF, 4'h6);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 86;
        3: idle_pct = 35;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue(pick_op(), pick_word(), pick_word(), 4'($urandom_range(15)));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/calu_pkg.sv
sv/calu_core.sv
sv/cpu_alu_with_flags.sv
sv/calu_checker.sv
bench/alu_flag_checker.sv
bench/tb_top.sv
